// ----- sv/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg: shared types and constants of the Morse character keyer
// Item layouts, element kinds, register indexes and the Morse code table.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int NUM_SLOTS = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_SETTING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAH_SETTING = 2'd3;

  localparam logic [9:0]  RST_ELEMENT_GAP = 10'd20;
  localparam logic [3:0]  RST_CHAR_FACTOR = 4'd9;
  localparam logic [7:0]  RST_DIT_SETTING = 8'h60;
  localparam logic [7:0]  RST_DAH_SETTING = 8'hff;

  localparam logic [13:0] GAP_LIMIT = 14'd15000;

  localparam logic [1:0] KIND_DIT = 2'd0;
  localparam logic [1:0] KIND_DAH = 2'd1;
  localparam logic [1:0] KIND_GAP = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_of_call;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  element_kind;
    logic [7:0]  radio_setting;
    logic [13:0] gap_ms;
    logic        last_of_run;
  } out_item_t;

  // One element slot held by a cell of the chain
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic       last;
  } slot_t;

  // Length in bits [7:5], pattern in [4:0]; first element is the highest
  // used pattern bit, 1 means dah. Zero for characters without a code.
  function automatic logic [7:0] morse_code(input logic [7:0] ch);
    logic [7:0] c;
    unique case (ch)
      8'h41: c = {3'd2, 5'h01}; // A
      8'h42: c = {3'd4, 5'h08};
      8'h43: c = {3'd4, 5'h0A};
      8'h44: c = {3'd3, 5'h04};
      8'h45: c = {3'd1, 5'h00};
      8'h46: c = {3'd4, 5'h02}; // F
      8'h47: c = {3'd3, 5'h06};
      8'h48: c = {3'd4, 5'h00};
      8'h49: c = {3'd2, 5'h00};
      8'h4A: c = {3'd4, 5'h07};
      8'h4B: c = {3'd3, 5'h05};
      8'h4C: c = {3'd4, 5'h04};
      8'h4D: c = {3'd2, 5'h03};
      8'h4E: c = {3'd2, 5'h02};
      8'h4F: c = {3'd3, 5'h07};
      8'h50: c = {3'd4, 5'h06};
      8'h51: c = {3'd4, 5'h0D};
      8'h52: c = {3'd3, 5'h02};
      8'h53: c = {3'd3, 5'h00};
      8'h54: c = {3'd1, 5'h01};
      8'h55: c = {3'd3, 5'h01};
      8'h56: c = {3'd4, 5'h01};
      8'h57: c = {3'd3, 5'h03};
      8'h58: c = {3'd4, 5'h09};
      8'h59: c = {3'd4, 5'h0B};
      8'h5A: c = {3'd4, 5'h0C}; // Z
      8'h30: c = {3'd5, 5'h1F}; // 0
      8'h31: c = {3'd5, 5'h0F};
      8'h32: c = {3'd5, 5'h07};
      8'h33: c = {3'd5, 5'h03};
      8'h34: c = {3'd5, 5'h01};
      8'h35: c = {3'd5, 5'h00};
      8'h36: c = {3'd5, 5'h10};
      8'h37: c = {3'd5, 5'h18};
      8'h38: c = {3'd5, 5'h1C};
      8'h39: c = {3'd5, 5'h1E}; // 9
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/mck_decode.sv -----
// ----------------------------------------------------------------------------
// mck_decode: element slot builder
// Lays out the run of one character over the slots of the cell chain.
// ----------------------------------------------------------------------------
module mck_decode (
  input  mck_pkg::in_item_t item,
  output mck_pkg::slot_t    slots [mck_pkg::NUM_SLOTS]
);

  logic [7:0] code;
  logic [2:0] len;
  logic [4:0] pat;
  logic [3:0] sym_start;
  logic [3:0] close_pos;

  always_comb begin
    code      = mck_pkg::morse_code(item.char_code);
    len       = code[7:5];
    pat       = code[4:0];
    sym_start = (item.first_of_call ? 4'd2 : 4'd0)
              + {3'd0, (item.char_code == mck_pkg::CHAR_SPACE)};
    close_pos = sym_start + {1'b0, len};
  end

  // Each slot is decided on its own position alone
  always_comb begin
    logic [3:0] pos;
    logic [3:0] sel;
    for (int i = 0; i < mck_pkg::NUM_SLOTS; i++) begin
      pos = 4'(i);
      sel = {1'b0, len} - 4'd1 - (pos - sym_start);
      slots[i] = '0;
      if (pos < sym_start) begin
        slots[i].vld  = 1'b1;
        slots[i].kind = mck_pkg::KIND_GAP;
      end else if (pos < close_pos) begin
        slots[i].vld  = 1'b1;
        slots[i].kind = ((pat >> sel) & 5'd1) != 5'd0 ? mck_pkg::KIND_DAH
                                                       : mck_pkg::KIND_DIT;
      end else if (pos == close_pos) begin
        slots[i].vld  = 1'b1;
        slots[i].kind = mck_pkg::KIND_GAP;
        slots[i].last = 1'b1;
      end
    end
  end

endmodule

// ----- sv/mck_cell.sv -----
// ----------------------------------------------------------------------------
// mck_cell: one element cell of the output chain
// Loads its slot on a new item, otherwise takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module mck_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           shift,
  input  mck_pkg::slot_t load_slot,
  input  mck_pkg::slot_t next_slot,
  output mck_pkg::slot_t slot
);

  mck_pkg::slot_t slot_r;
  mck_pkg::slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (load) begin
      slot_nxt = load_slot;
    end else if (shift) begin
      slot_nxt = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

// ----- sv/morse_character_keyer_unit.sv -----
// ----------------------------------------------------------------------------
// morse_character_keyer_unit: Morse character keyer
// Turns one call sign character per item into a run of keying elements.
// ----------------------------------------------------------------------------
//
//   port group | dir | handshake          | payload
//   -----------+-----+--------------------+----------------------------------
//   in_        | in  | in_valid/in_stall  | char_code, first_of_call
//   out_       | out | out_valid/out_stall| element_kind, radio_setting,
//              |     |                    | gap_ms, last_of_run
//   cfg_       | in  | cfg_we             | cfg_index, cfg_data
//
// An item loads its whole run (one to eight elements) into a chain of eight
// cells at once; the head cell is the result item and the chain shifts
// one place each time a result is taken. A new item is taken in the same
// cycle that the last element of the previous run leaves, so runs follow
// without a bubble. Reset clears every cell and loads the register
// defaults. Result stall holds the chain, and input stall stays high until
// only the head cell holds an element and it is not stalled.
//
module morse_character_keyer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mck_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mck_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [mck_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mck_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers
  logic [9:0]  elem_gap_r;
  logic [3:0]  factor_r;
  logic [7:0]  dit_r;
  logic [7:0]  dah_r;

  // Character gap, product of element gap and factor, saturated
  logic [13:0] cgap_r;
  logic [13:0] cgap_nxt;
  logic [13:0] cgap_prod;

  mck_pkg::slot_t new_slots [mck_pkg::NUM_SLOTS];
  mck_pkg::slot_t cells     [mck_pkg::NUM_SLOTS];

  logic load;
  logic shift;
  logic tail_busy;

  // Register writes; unknown indexes cannot occur with a two-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_gap_r <= mck_pkg::RST_ELEMENT_GAP;
      factor_r   <= mck_pkg::RST_CHAR_FACTOR;
      dit_r      <= mck_pkg::RST_DIT_SETTING;
      dah_r      <= mck_pkg::RST_DAH_SETTING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mck_pkg::CFG_ELEMENT_GAP: elem_gap_r <= cfg_data[9:0];
        mck_pkg::CFG_CHAR_FACTOR: factor_r   <= cfg_data[3:0];
        mck_pkg::CFG_DIT_SETTING: dit_r      <= cfg_data[7:0];
        mck_pkg::CFG_DAH_SETTING: dah_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Recompute the character gap every cycle into a register; it settles after a
  // write, before any item written after it can reach the output
  always_comb begin
    cgap_prod = {4'd0, elem_gap_r} * {10'd0, factor_r};
    cgap_nxt  = (cgap_prod > mck_pkg::GAP_LIMIT) ? mck_pkg::GAP_LIMIT : cgap_prod;
  end

  always_ff @(posedge clk) begin
    cgap_r <= cgap_nxt;
  end

  mck_decode u_decode (
    .item  (in_item),
    .slots (new_slots)
  );

  // Hold input while anything behind the head waits, or the head is stalled
  always_comb begin
    tail_busy = 1'b0;
    for (int i = 1; i < mck_pkg::NUM_SLOTS; i++) begin
      tail_busy = tail_busy | cells[i].vld;
    end
  end

  assign out_valid = cells[0].vld;
  assign shift     = out_valid & ~out_stall;
  assign in_stall  = tail_busy | (cells[0].vld & out_stall);
  assign load      = in_valid & ~in_stall;

  // Chain of cells; the last one takes an empty slot on a shift
  for (genvar g = 0; g < mck_pkg::NUM_SLOTS; g++) begin : g_cell
    mck_pkg::slot_t next_slot;
    if (g == mck_pkg::NUM_SLOTS - 1) begin : g_end
      assign next_slot = '0;
    end else begin : g_mid
      assign next_slot = cells[g+1];
    end
    mck_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load),
      .shift     (shift),
      .load_slot (new_slots[g]),
      .next_slot (next_slot),
      .slot      (cells[g])
    );
  end

  // Fill the result fields from the head cell's kind
  always_comb begin
    out_item              = '0;
    out_item.element_kind = cells[0].kind;
    out_item.last_of_run  = cells[0].last;
    case (cells[0].kind)
      mck_pkg::KIND_DIT: begin
        out_item.radio_setting = dit_r;
        out_item.gap_ms        = {4'd0, elem_gap_r};
      end
      mck_pkg::KIND_DAH: begin
        out_item.radio_setting = dah_r;
        out_item.gap_ms        = {4'd0, elem_gap_r};
      end
      default: begin
        out_item.radio_setting = 8'd0;
        out_item.gap_ms        = cgap_r;
      end
    endcase
  end

endmodule
